>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tile edge dissimilarity block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a condition leads to a consequence on the next clock edge.
`define TED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ted_pkg.sv
// ---------------------------------------------------------------------------
// ted_pkg
// Widths, state encoding and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ted_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int CUBE_W     = 3 * PIX_W;
  localparam int SUM_W      = 32;
  localparam int TOT_W      = SUM_W + 1;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int IN_DATA_W  = 2 * NUM_CH * PIX_W;
  localparam int OUT_DATA_W = ROOT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQR  = 6'b000010,
    S_CUBE = 6'b000100,
    S_ACC  = 6'b001000,
    S_ROOT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_sqr;
    logic do_cube;
    logic do_acc;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic root_last;
  } sts_t;

endpackage

>>> src/ted_ctrl.sv
// ---------------------------------------------------------------------------
// ted_ctrl
// Sequencer for one pixel pair at a time, plus the result beat valid flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ted_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output ted_pkg::cmd_t cmd,
  input  ted_pkg::sts_t sts
);
  import ted_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQR;
        end
      end
      S_SQR: begin
        cmd.do_sqr = 1'b1;
        state_nxt  = S_CUBE;
      end
      S_CUBE: begin
        cmd.do_cube = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.do_acc = 1'b1;
        state_nxt  = sts.last ? S_ROOT : S_IDLE;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // A new result may only overwrite the output register once it is free.
  `TED_ASSERT(a_out_load_free, cmd.out_load |-> (!out_valid_r || out_tready), "result overwritten")
  // The last root iteration hands over to the result stage.
  `TED_ASSERT_NEXT(a_root_to_done, state_r == S_ROOT && sts.root_last, state_r == S_DONE, "root end lost")

endmodule

>>> src/ted_dp.sv
// ---------------------------------------------------------------------------
// ted_dp
// Cube-sum accumulator, bit-pair square root and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ted_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ted_pkg::cmd_t                     cmd,
  output ted_pkg::sts_t                     sts,
  input  logic [ted_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  output logic [ted_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser
);
  import ted_pkg::*;

  logic [PIX_W-1:0]      diff_r [NUM_CH];
  logic [SQ_W-1:0]       sq_r   [NUM_CH];
  logic [CUBE_W-1:0]     cube_r [NUM_CH];
  logic                  last_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  ovf_r;
  logic [SUM_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  sat_r;
  logic [ROOT_W-1:0]     dis_r;
  logic                  out_sat_r;

  logic [PIX_W-1:0]      a_pix [NUM_CH];
  logic [PIX_W-1:0]      b_pix [NUM_CH];
  logic [TOT_W-1:0]      total;
  logic [REM_W+1:0]      rem_sh;
  logic [REM_W+1:0]      trial;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      a_pix[c] = in_tdata[c*PIX_W +: PIX_W];
      b_pix[c] = in_tdata[(NUM_CH+c)*PIX_W +: PIX_W];
    end
  end

  // Add of the three cubes onto the running sum, one extra bit for overflow.
  always_comb begin
    total = {1'b0, sum_r};
    for (int c = 0; c < NUM_CH; c++) begin
      total = total + TOT_W'(cube_r[c]);
    end
  end

  assign rem_sh = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int c = 0; c < NUM_CH; c++) begin
        diff_r[c] <= (a_pix[c] >= b_pix[c]) ? a_pix[c] - b_pix[c] : b_pix[c] - a_pix[c];
      end
      last_r <= in_tlast;
    end
    if (cmd.do_sqr) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sq_r[c] <= SQ_W'(diff_r[c]) * SQ_W'(diff_r[c]);
      end
    end
    if (cmd.do_cube) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cube_r[c] <= CUBE_W'(sq_r[c]) * CUBE_W'(diff_r[c]);
      end
    end
    if (cmd.do_acc && last_r) begin
      rad_r <= total[TOT_W-1] ? '1 : total[SUM_W-1:0];
      sat_r <= ovf_r | total[TOT_W-1];
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[SUM_W-3:0], 2'b00};
    end
    if (cmd.out_load) begin
      dis_r     <= root_r;
      out_sat_r <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      ovf_r  <= 1'b0;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.do_acc) begin
        if (last_r) begin
          sum_r  <= '0;
          ovf_r  <= 1'b0;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end else if (total[TOT_W-1]) begin
          sum_r <= '1;
          ovf_r <= 1'b1;
        end else begin
          sum_r <= total[SUM_W-1:0];
        end
      end else if (cmd.root_step) begin
        if (rem_sh >= trial) begin
          rem_r  <= REM_W'(rem_sh - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + ROOT_CNT_W'(1);
      end
    end
  end

  assign sts.last      = last_r;
  assign sts.root_last = (cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1));
  assign out_tdata     = dis_r;
  assign out_tuser     = out_sat_r;

  // The partial remainder never exceeds twice the partial root.
  `TED_ASSERT(a_rem_bound, rem_r <= {1'b0, root_r, 1'b0}, "root remainder out of range")
  // Closing a border leaves a clean accumulator for the next one.
  `TED_ASSERT_NEXT(a_sum_clear, cmd.do_acc && last_r, sum_r == '0 && !ovf_r, "sum not cleared")

endmodule

>>> src/tile_edge_dissimilarity_core.sv
// ---------------------------------------------------------------------------
// tile_edge_dissimilarity_core
// Border-fit score of two image tiles from facing pixel pairs.
// ---------------------------------------------------------------------------
// Each input beat carries one pixel pair facing across a tile border. The
// block cubes the absolute red, green and blue differences and adds them to
// a 32-bit running sum that clamps at all ones. On the beat with in_tlast
// high it produces one result beat: the floor of the square root of the sum,
// with out_tuser set if the sum was clamped anywhere in that border; the sum
// is then cleared. A pixel pair that does not close a border holds the block
// through its capture, square, cube and accumulate steps, after which
// in_tready is high again. The closing pair also runs the 16-iteration
// bit-pair square root and then waits, if need be, for the output register
// to drain. A finished result waits in its own register, so a new border
// can start while the previous score has not yet been taken.
// ---------------------------------------------------------------------------

module tile_edge_dissimilarity_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, from bit 0 up: a_red, a_green, a_blue, b_red, b_green, b_blue.
  input  logic [ted_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,   // last_pixel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata, from bit 0 up: dissimilarity.
  output logic [ted_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser,  // saturated
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import ted_pkg::*;

  // Command and status buses between the sequencer and the arithmetic.
  cmd_t cmd;
  sts_t sts;

  // The sequencer owns both handshakes; the datapath only sees commands.
  ted_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath holds the accumulator, the root unit and the result register.
  ted_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
